@@ hdl/mlr_pkg.sv @@
// ----------------------------------------------------------------------------
// mlr_pkg: shared constants and types for the midpoint line rasterizer
// Holds coordinate widths, stream widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlr_pkg;

    // Width of one coordinate.
    localparam int COORD_BITS = 6;

    // Signed width of the decision term and of its increments.
    localparam int DTERM_BITS = COORD_BITS + 3;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // Capture the endpoints of a new request.
        logic order;  // Pick the major axis and order the endpoints.
        logic init;   // Compute spans, increments and the first decision term.
        logic emit;   // Send the current pixel and take one major step.
    } mlr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // The output register can take a pixel this cycle.
        logic at_end;    // The current pixel is the last of the segment.
    } mlr_sts_t;

endpackage

`default_nettype wire

@@ hdl/mlr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlr_ctrl: sequencing controller of the midpoint line rasterizer
// Walks each segment through load, ordering, setup and the pixel loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlr_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  mlr_pkg::mlr_sts_t     sts,
    output mlr_pkg::mlr_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ORDER = 4'b0010,
        ST_INIT  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A new request is taken only while no segment is in progress.
    assign s_tready = (state_reg == ST_IDLE);

    // Command decode.
    always_comb begin
        cmd       = '0;
        cmd.load  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.order = (state_reg == ST_ORDER);
        cmd.init  = (state_reg == ST_INIT);
        cmd.emit  = (state_reg == ST_EMIT) && sts.out_free;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_ORDER;
                end
            end
            ST_ORDER: begin
                state_next = ST_INIT;
            end
            ST_INIT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free && sts.at_end) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/mlr_dpath.sv @@
// ----------------------------------------------------------------------------
// mlr_dpath: datapath of the midpoint line rasterizer
// Holds endpoints, positions, the decision term and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlr_dpath (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  mlr_pkg::mlr_cmd_t                       cmd,
    output mlr_pkg::mlr_sts_t                       sts,
    input  wire logic [mlr_pkg::S_TDATA_BITS-1:0]   s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [mlr_pkg::M_TDATA_BITS-1:0]   m_tdata,
    output logic                                    m_tlast
);

    localparam int C  = mlr_pkg::COORD_BITS;
    localparam int DW = mlr_pkg::DTERM_BITS;

    // Captured endpoints.
    logic [C-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    // Walk state.
    logic [C-1:0]  major_pos_reg, major_pos_next;
    logic [C-1:0]  minor_pos_reg, minor_pos_next;
    logic [C-1:0]  major_end_reg, major_end_next;
    logic [C-1:0]  minor_end_reg, minor_end_next;
    logic          steep_reg, steep_next;
    logic          step_down_reg, step_down_next;
    logic [DW-1:0] dterm_reg, dterm_next;
    logic [DW-1:0] plain_inc_reg, plain_inc_next;
    logic [DW-1:0] diag_inc_reg, diag_inc_next;

    // Output register.
    logic          m_tvalid_reg, m_tvalid_next;
    logic [C-1:0]  pixel_x_reg, pixel_y_reg;
    logic          last_reg;

    // Ordering terms.
    logic [C-1:0]  adx, ady;
    logic          steep;
    logic [C-1:0]  pa0, pi0, pa1, pi1;
    logic          swap;

    // Setup terms.
    logic [C-1:0]  major_span;
    logic          step_down;
    logic [C-1:0]  minor_span;
    logic [DW-1:0] minor_x2;

    // Step terms.
    logic          diag_step;

    // Status toward the controller.
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign sts.at_end   = (major_pos_reg >= major_end_reg);

    // Absolute spans, major axis choice and ordering along it.
    always_comb begin
        adx   = (sx_reg > ex_reg) ? (sx_reg - ex_reg) : (ex_reg - sx_reg);
        ady   = (sy_reg > ey_reg) ? (sy_reg - ey_reg) : (ey_reg - sy_reg);
        steep = (ady > adx);
        pa0   = steep ? sy_reg : sx_reg;
        pi0   = steep ? sx_reg : sy_reg;
        pa1   = steep ? ey_reg : ex_reg;
        pi1   = steep ? ex_reg : ey_reg;
        swap  = (pa0 > pa1);
    end

    // Spans of the ordered segment and the minor direction.
    always_comb begin
        major_span = major_end_reg - major_pos_reg;
        step_down  = (minor_end_reg < minor_pos_reg);
        minor_span = step_down ? (minor_pos_reg - minor_end_reg)
                               : (minor_end_reg - minor_pos_reg);
        minor_x2   = {2'b00, minor_span, 1'b0};
    end

    // A diagonal step is taken while the decision term is positive.
    assign diag_step = !dterm_reg[DW-1] && (dterm_reg != '0);

    // Next values of the walk state.
    always_comb begin
        major_pos_next = major_pos_reg;
        minor_pos_next = minor_pos_reg;
        major_end_next = major_end_reg;
        minor_end_next = minor_end_reg;
        steep_next     = steep_reg;
        step_down_next = step_down_reg;
        dterm_next     = dterm_reg;
        plain_inc_next = plain_inc_reg;
        diag_inc_next  = diag_inc_reg;
        if (cmd.order) begin
            steep_next     = steep;
            major_pos_next = swap ? pa1 : pa0;
            minor_pos_next = swap ? pi1 : pi0;
            major_end_next = swap ? pa0 : pa1;
            minor_end_next = swap ? pi0 : pi1;
        end
        if (cmd.init) begin
            step_down_next = step_down;
            plain_inc_next = minor_x2;
            diag_inc_next  = minor_x2 - {2'b00, major_span, 1'b0};
            dterm_next     = minor_x2 - {3'b000, major_span};
        end
        if (cmd.emit) begin
            major_pos_next = major_pos_reg + C'(1);
            if (diag_step) begin
                dterm_next     = dterm_reg + diag_inc_reg;
                minor_pos_next = step_down_reg ? (minor_pos_reg - C'(1))
                                               : (minor_pos_reg + C'(1));
            end else begin
                dterm_next = dterm_reg + plain_inc_reg;
            end
        end
    end

    // Output valid: set by a new pixel, cleared when the pixel is taken.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sx_reg <= s_tdata[C-1:0];
            sy_reg <= s_tdata[2*C-1:C];
            ex_reg <= s_tdata[3*C-1:2*C];
            ey_reg <= s_tdata[4*C-1:3*C];
        end
        major_pos_reg <= major_pos_next;
        minor_pos_reg <= minor_pos_next;
        major_end_reg <= major_end_next;
        minor_end_reg <= minor_end_next;
        steep_reg     <= steep_next;
        step_down_reg <= step_down_next;
        dterm_reg     <= dterm_next;
        plain_inc_reg <= plain_inc_next;
        diag_inc_reg  <= diag_inc_next;
        if (cmd.emit) begin
            pixel_x_reg <= steep_reg ? minor_pos_reg : major_pos_reg;
            pixel_y_reg <= steep_reg ? major_pos_reg : minor_pos_reg;
            last_reg    <= sts.at_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = mlr_pkg::M_TDATA_BITS'({pixel_y_reg, pixel_x_reg});
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

@@ hdl/midpoint_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer: all-octant midpoint line rasterizer
//
// The slave stream takes one segment per request as two endpoints. The
// master stream returns every pixel of that segment in ascending order
// along the major axis (the axis with the larger span, x on a tie), both
// endpoints included; m_tlast marks the final pixel.
// A request is accepted only while no segment is in progress. After the
// accepting edge, the ORDER and INIT states order the endpoints and set
// up the decision term, and the EMIT state loads the first pixel into the
// output register once that register is free. The pixel loop then
// delivers one pixel per cycle while m_tready is high. The one-pixel
// output register sets the loop pace: while the receiver stalls, the loop
// holds its place and the pixel stays on m_tdata. The next request can be
// taken while the last pixel still waits in the output register.
// Reset (aresetn low at a clock edge) returns the controller to idle and
// drops any pending pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midpoint_line_rasterizer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata fields from bit 0: start_x, start_y, end_x, end_y.
    input  wire logic [mlr_pkg::S_TDATA_BITS-1:0]   s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata fields from bit 0: pixel_x, pixel_y, then zero padding.
    output logic      [mlr_pkg::M_TDATA_BITS-1:0]   m_tdata,
    // m_tlast carries last_pixel.
    output logic                                    m_tlast
);

    mlr_pkg::mlr_cmd_t cmd;
    mlr_pkg::mlr_sts_t sts;

    // Sequencer.
    mlr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic and output register.
    mlr_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // An accepted request keeps the input closed on the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while a segment was starting");

    // A pending pixel that is not the last one means the segment is running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input opened before the segment was complete");

    // The pixel loop refills the output register right after a non-last pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap in the pixel stream within a segment");

    // The command set is exclusive.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.order, cmd.init, cmd.emit}))
        else $error("more than one datapath command at once");

endmodule

`default_nettype wire

@@ tb/sv/midpoint_line_rasterizer_tb.sv @@
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_tb: self-checking bench for the line rasterizer
// Segments are fed through the slave stream from a queue of pending
// requests. Every accepted segment is rasterized by a behavioral model in
// the bench, and each pixel on the master stream is compared with the
// oldest predicted pixel. Both stream sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module midpoint_line_rasterizer_tb;

    localparam int C           = mlr_pkg::COORD_BITS;
    localparam int S_BITS      = mlr_pkg::S_TDATA_BITS;
    localparam int M_BITS      = mlr_pkg::M_TDATA_BITS;
    localparam int D_BITS      = mlr_pkg::DTERM_BITS;
    localparam int STALL_PCT   = 12;
    localparam int RAND_SEGS   = 380;
    localparam int TAIL_CYCLES = 80;
    localparam int STUCK_LIMIT = 1000;

    // One segment request; start_x sits in the lowest bits.
    typedef struct packed {
        logic [C-1:0] end_y;
        logic [C-1:0] end_x;
        logic [C-1:0] start_y;
        logic [C-1:0] start_x;
    } segment_t;

    // One plotted pixel.
    typedef struct packed {
        logic [C-1:0] px;
        logic [C-1:0] py;
        logic         last;
    } pixel_t;

    logic                      aclk     = 1'b0;
    logic                      aresetn  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_BITS-1:0]         s_tdata  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_BITS-1:0]         m_tdata;
    logic                      m_tlast;

    segment_t pending_segs[$];
    pixel_t   pixel_queue[$];
    segment_t cur_seg;
    int       segs_taken  = 0;
    int       err_count   = 0;
    int       cycle_count = 0;
    int       stuck_count = 0;
    logic     quiet;

    midpoint_line_rasterizer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    initial begin
        forever #2 aclk = ~aclk;
    end

    // A long window in the middle of the run has no stalls on either side.
    assign quiet = (cycle_count >= 4000) && (cycle_count < 8000);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic segment_t make_seg(int sx, int sy, int ex, int ey);
        segment_t seg;
        seg.start_x = C'(sx);
        seg.start_y = C'(sy);
        seg.end_x   = C'(ex);
        seg.end_y   = C'(ey);
        return seg;
    endfunction

    function automatic int clamp_coord(int v);
        int hi;
        hi = (1 << C) - 1;
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    // Rasterize one segment with the midpoint rule and queue its pixels.
    function automatic void rasterize_segment(segment_t seg);
        logic [C-1:0]              adx, ady, ma0, mi0, ma1, mi1, tmp;
        logic [C-1:0]              major_at, minor_at;
        logic signed [D_BITS-1:0]  dterm, plain_inc, diag_inc;
        logic                      steep, step_down;
        int                        major_span, minor_span;
        pixel_t                    pix;
        adx = (seg.end_x > seg.start_x) ? seg.end_x - seg.start_x : seg.start_x - seg.end_x;
        ady = (seg.end_y > seg.start_y) ? seg.end_y - seg.start_y : seg.start_y - seg.end_y;
        steep = ady > adx;
        if (steep) begin
            ma0 = seg.start_y; mi0 = seg.start_x; ma1 = seg.end_y; mi1 = seg.end_x;
        end else begin
            ma0 = seg.start_x; mi0 = seg.start_y; ma1 = seg.end_x; mi1 = seg.end_y;
        end
        // Order the endpoints so the major coordinate ascends.
        if (ma0 > ma1) begin
            tmp = ma0; ma0 = ma1; ma1 = tmp;
            tmp = mi0; mi0 = mi1; mi1 = tmp;
        end
        major_span = int'(ma1) - int'(ma0);
        step_down  = mi1 < mi0;
        minor_span = step_down ? int'(mi0) - int'(mi1) : int'(mi1) - int'(mi0);
        dterm      = D_BITS'(2 * minor_span - major_span);
        plain_inc  = D_BITS'(2 * minor_span);
        diag_inc   = D_BITS'(2 * (minor_span - major_span));
        major_at   = ma0;
        minor_at   = mi0;
        for (int k = 0; k <= major_span; k++) begin
            if (k > 0) begin
                if (dterm <= 0) begin
                    dterm = dterm + plain_inc;
                end else begin
                    dterm    = dterm + diag_inc;
                    minor_at = step_down ? minor_at - 1'b1 : minor_at + 1'b1;
                end
                major_at = major_at + 1'b1;
            end
            pix.px   = steep ? minor_at : major_at;
            pix.py   = steep ? major_at : minor_at;
            pix.last = (k == major_span);
            pixel_queue.push_back(pix);
        end
    endfunction

    // Request driver: predicts each accepted segment and presents the next.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                rasterize_segment(cur_seg);
                segs_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_segs.size() != 0 &&
                    (quiet || $urandom_range(0, 99) >= STALL_PCT)) begin
                    cur_seg = pending_segs.pop_front();
                    s_tdata  <= S_BITS'(cur_seg);
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Pixel receiver with random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(0, 99) >= STALL_PCT);
        end
    end

    // Pixel monitor: compares each accepted pixel with the oldest prediction.
    always @(posedge aclk) begin : pixel_check
        pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.px   = m_tdata[C-1:0];
            got.py   = m_tdata[2*C-1:C];
            got.last = m_tlast;
            if (pixel_queue.size() == 0) begin
                if (err_count < 10)
                    $display("%0t: unexpected pixel x=%0d y=%0d last=%0b",
                             $realtime, got.px, got.py, got.last);
                err_count++;
            end else begin
                want = pixel_queue.pop_front();
                if (got !== want) begin
                    if (err_count < 10)
                        $display("%0t: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                                 $realtime, want.px, want.py, want.last,
                                 got.px, got.py, got.last);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no request or pixel moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stuck_count <= 0;
            end else if (stuck_count >= STUCK_LIMIT) begin
                $display("[midpoint_line_rasterizer] ERROR");
                $finish;
            end else begin
                stuck_count <= stuck_count + 1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int kind, sx, sy, ex, ey, len, hi, total;
        hi = (1 << C) - 1;

        // Directed segments: points, axis-aligned lines, diagonals, octants.
        pending_segs.push_back(make_seg(0, 0, 0, 0));
        pending_segs.push_back(make_seg(hi, hi, hi, hi));
        pending_segs.push_back(make_seg(0, 0, hi, 0));
        pending_segs.push_back(make_seg(hi, hi, 0, hi));
        pending_segs.push_back(make_seg(0, 0, 0, hi));
        pending_segs.push_back(make_seg(hi, hi, hi, 0));
        pending_segs.push_back(make_seg(0, 0, hi, hi));
        pending_segs.push_back(make_seg(hi, 0, 0, hi));
        pending_segs.push_back(make_seg(0, hi, hi, 0));
        pending_segs.push_back(make_seg(hi, hi, 0, 0));
        pending_segs.push_back(make_seg(10, 20, 40, 30));
        pending_segs.push_back(make_seg(40, 30, 10, 20));
        pending_segs.push_back(make_seg(10, 30, 40, 20));
        pending_segs.push_back(make_seg(40, 20, 10, 30));
        pending_segs.push_back(make_seg(20, 10, 30, 40));
        pending_segs.push_back(make_seg(30, 40, 20, 10));
        pending_segs.push_back(make_seg(30, 10, 20, 40));
        pending_segs.push_back(make_seg(20, 40, 30, 10));
        pending_segs.push_back(make_seg(5, 5, 6, 7));
        pending_segs.push_back(make_seg(42, 21, 21, 42));
        pending_segs.push_back(make_seg(0, hi, hi - 1, 0));

        // Random segments of several shapes, some of them short.
        for (int i = 0; i < RAND_SEGS; i++) begin
            kind = $urandom_range(0, 9);
            sx = $urandom_range(0, hi);
            sy = $urandom_range(0, hi);
            ex = $urandom_range(0, hi);
            ey = $urandom_range(0, hi);
            case (kind)
                4, 5: begin
                    ex = clamp_coord(sx + $urandom_range(0, 10) - 5);
                    ey = clamp_coord(sy + $urandom_range(0, 10) - 5);
                end
                6: begin
                    len = $urandom_range(0, 20);
                    ex = clamp_coord($urandom_range(0, 1) ? sx + len : sx - len);
                    ey = clamp_coord($urandom_range(0, 1) ? sy + len : sy - len);
                end
                7: begin
                    if ($urandom_range(0, 1)) ey = sy;
                    else ex = sx;
                end
                8: begin
                    ex = hi - $urandom_range(0, 3);
                    sx = $urandom_range(0, 3);
                    if ($urandom_range(0, 1)) begin
                        len = sx; sx = ex; ex = len;
                    end
                end
                9: begin
                    ex = sx;
                    ey = sy;
                end
                default: begin
                end
            endcase
            pending_segs.push_back(make_seg(sx, sy, ex, ey));
        end
        total = pending_segs.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every segment was taken and every pixel came back.
        while (segs_taken < total || pixel_queue.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_count == 0 && pixel_queue.size() == 0) begin
            $display("[midpoint_line_rasterizer] OK");
        end else begin
            $display("[midpoint_line_rasterizer] ERROR");
        end
        $finish;
    end

endmodule
